### hdl/chd_pkg.sv
// ----------------------------------------------------------------------------
// chd_pkg: shared types and constants of the chunked body decoder
// Decoder state, result beat, character codes and hex/white-space helpers.
// ----------------------------------------------------------------------------
package chd_pkg;

	// width of the chunk size counter and longest size line
	localparam int SIZE_BITS = 32;
	localparam int MAX_LINE  = 255;
	localparam int LINE_W    = $clog2(MAX_LINE + 1);

	// line length limits
	localparam logic [LINE_W-1:0] LINE_PARSE_LIM = LINE_W'(MAX_LINE - 2);
	localparam logic [LINE_W-1:0] LINE_MAX       = LINE_W'(MAX_LINE);

	// command codes
	localparam logic FUNC_BYTE    = 1'b0;
	localparam logic FUNC_RESTART = 1'b1;

	// character codes
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_VT    = 8'h0B;
	localparam logic [7:0] CH_FF    = 8'h0C;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_UA    = 8'h41;
	localparam logic [7:0] CH_UF    = 8'h46;
	localparam logic [7:0] CH_UX    = 8'h58;
	localparam logic [7:0] CH_LA    = 8'h61;
	localparam logic [7:0] CH_LF_A  = 8'h66;
	localparam logic [7:0] CH_LX    = 8'h78;

	typedef enum logic [1:0] {
		PH_LINE,
		PH_DATA,
		PH_TRAIL,
		PH_ENDTRAIL
	} phase_t;

	typedef enum logic [1:0] {
		NS_SPACE,
		NS_ZERO,
		NS_DIGITS,
		NS_DONE
	} nstage_t;

	typedef struct packed {
		phase_t                phase;
		logic [SIZE_BITS-1:0]  size;
		logic [LINE_W-1:0]     line_cnt;
		logic                  prev_cr;
		nstage_t               nstage;
		logic                  skip;
	} state_t;

	typedef struct packed {
		logic [7:0] byte_out;
		logic       last_of_chunk;
		logic       body_end;
	} beat_t;

	localparam state_t STATE_START = '{
		phase:    PH_LINE,
		size:     '0,
		line_cnt: '0,
		prev_cr:  1'b0,
		nstage:   NS_SPACE,
		skip:     1'b0
	};

	// white space as skipped before the number
	function automatic logic is_space(input logic [7:0] c);
		return (c == CH_SPACE) || (c inside {[CH_TAB:CH_CR]});
	endfunction

	// hex digit decode: bit 4 flags a digit, low bits carry its value
	function automatic logic [4:0] hex_decode(input logic [7:0] c);
		logic [4:0] r;
		r = '0;
		if (c inside {[CH_ZERO:CH_NINE]})
			r = {1'b1, 4'(c - CH_ZERO)};
		else if (c inside {[CH_LA:CH_LF_A]})
			r = {1'b1, 4'(c - CH_LA + 8'd10)};
		else if (c inside {[CH_UA:CH_UF]})
			r = {1'b1, 4'(c - CH_UA + 8'd10)};
		return r;
	endfunction

endpackage

### hdl/http_chunked_body_decoder_core.sv
// A payload or body end beat is registered in the output stage, or held in the skid stage.
// One byte or restart per cycle unless stalled; size line and trailer give no payload beat.
// The skid stage lets input run on while an output beat waits; input stalls only when full.
// Reset clears the decoder to expect a size line and empties the output stages.
// ----------------------------------------------------------------------------
// http_chunked_body_decoder_core: chunked transfer body decoder
// Parses hex chunk size lines, forwards payload bytes and flags body end.
// ----------------------------------------------------------------------------
module http_chunked_body_decoder_core
	import chd_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic       func,
	input  logic [7:0] byte_in,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] byte_out,
	output logic       last_of_chunk,
	output logic       body_end
);

	state_t state_q;
	state_t state_nxt;
	logic   has_beat;
	beat_t  beat;
	beat_t  out_beat;
	logic   skid_full;
	logic   take;

	assign in_stall = skid_full;
	assign take     = in_valid && !skid_full;

	chd_step u_step (
		.cur      (state_q),
		.func     (func),
		.byte_in  (byte_in),
		.nxt      (state_nxt),
		.has_beat (has_beat),
		.beat     (beat)
	);

	// decoder state, updated once per input beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= STATE_START;
		else if (take)
			state_q <= state_nxt;
	end

	chd_out_skid u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (take && has_beat),
		.push_beat (beat),
		.full      (skid_full),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_beat  (out_beat)
	);

	assign byte_out      = out_beat.byte_out;
	assign last_of_chunk = out_beat.last_of_chunk;
	assign body_end      = out_beat.body_end;

endmodule

### hdl/chd_step.sv
// ----------------------------------------------------------------------------
// chd_step: next state and result of one received byte
// Size line parsing, payload countdown and trailer drop in one pass.
// ----------------------------------------------------------------------------
module chd_step
	import chd_pkg::*;
(
	input  state_t cur,
	input  logic   func,
	input  logic [7:0] byte_in,
	output state_t nxt,
	output logic   has_beat,
	output beat_t  beat
);

	logic [4:0]           hex;
	logic                 is_digit;
	logic [3:0]           digit;
	logic                 sat;
	logic [SIZE_BITS-1:0] size_dig;
	logic [SIZE_BITS-1:0] size_parsed;
	nstage_t              ns_parsed;
	logic [LINE_W-1:0]    len_inc;
	logic                 ended;
	logic [SIZE_BITS-1:0] remain;

	assign hex      = hex_decode(byte_in);
	assign is_digit = hex[4];
	assign digit    = hex[3:0];

	// saturating shift in of one hex digit
	assign sat      = cur.size[SIZE_BITS-1:SIZE_BITS-4] != '0;
	assign size_dig = sat ? '1 : {cur.size[SIZE_BITS-5:0], digit};

	// number parse of a size line byte
	always_comb begin
		size_parsed = cur.size;
		ns_parsed   = cur.nstage;
		if (cur.line_cnt < LINE_PARSE_LIM) begin
			case (cur.nstage)
				NS_SPACE: begin
					if (is_space(byte_in)) begin
						ns_parsed = NS_SPACE;
					end else if (byte_in == CH_ZERO) begin
						size_parsed = '0;
						ns_parsed   = NS_ZERO;
					end else if (is_digit) begin
						size_parsed = SIZE_BITS'(digit);
						ns_parsed   = NS_DIGITS;
					end else begin
						size_parsed = '0;
						ns_parsed   = NS_DONE;
					end
				end
				NS_ZERO: begin
					if (byte_in == CH_LX || byte_in == CH_UX) begin
						ns_parsed = NS_DIGITS;
					end else if (is_digit) begin
						size_parsed = size_dig;
						ns_parsed   = NS_DIGITS;
					end else begin
						ns_parsed = NS_DONE;
					end
				end
				NS_DIGITS: begin
					if (is_digit)
						size_parsed = size_dig;
					else
						ns_parsed = NS_DONE;
				end
				default: begin
					ns_parsed = NS_DONE;
				end
			endcase
		end
	end

	// line end on cr lf or at the length limit
	assign len_inc = cur.line_cnt + 1'b1;
	assign ended   = (cur.prev_cr && byte_in == CH_LF) || (len_inc >= LINE_MAX);
	assign remain  = cur.size - 1'b1;

	// phase sequencing and result beat
	always_comb begin
		nxt      = cur;
		has_beat = 1'b0;
		beat     = '{byte_out: byte_in, last_of_chunk: 1'b0, body_end: 1'b0};
		if (func == FUNC_RESTART) begin
			nxt = STATE_START;
		end else begin
			case (cur.phase)
				PH_LINE: begin
					nxt.size     = size_parsed;
					nxt.nstage   = ns_parsed;
					nxt.line_cnt = len_inc;
					nxt.prev_cr  = byte_in == CH_CR;
					if (ended) begin
						nxt.line_cnt = '0;
						nxt.prev_cr  = 1'b0;
						nxt.nstage   = NS_SPACE;
						nxt.skip     = 1'b0;
						nxt.phase    = (size_parsed == '0) ? PH_ENDTRAIL : PH_DATA;
					end
				end
				PH_DATA: begin
					nxt.size            = remain;
					has_beat            = 1'b1;
					beat.last_of_chunk  = remain == '0;
					if (remain == '0) begin
						nxt.phase = PH_TRAIL;
						nxt.skip  = 1'b0;
					end
				end
				PH_TRAIL: begin
					if (!cur.skip)
						nxt.skip = 1'b1;
					else
						nxt = STATE_START;
				end
				PH_ENDTRAIL: begin
					if (!cur.skip) begin
						nxt.skip = 1'b1;
					end else begin
						nxt      = STATE_START;
						has_beat = 1'b1;
						beat     = '{byte_out: 8'h00, last_of_chunk: 1'b0, body_end: 1'b1};
					end
				end
				default: begin
					nxt = STATE_START;
				end
			endcase
		end
	end

endmodule

### hdl/chd_out_skid.sv
// ----------------------------------------------------------------------------
// chd_out_skid: output register with skid stage
// Holds result beats so the input side keeps running while the output stalls.
// ----------------------------------------------------------------------------
module chd_out_skid
	import chd_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  beat_t push_beat,
	output logic  full,
	output logic  out_valid,
	input  logic  out_stall,
	output beat_t out_beat
);

	logic  out_vld_q;
	beat_t out_q;
	logic  skid_vld_q;
	beat_t skid_q;
	logic  out_free;

	// output slot is free when empty or its beat leaves this cycle
	assign out_free = !out_vld_q || !out_stall;

	// valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q  <= 1'b0;
			skid_vld_q <= 1'b0;
		end else if (out_free) begin
			out_vld_q  <= skid_vld_q || push;
			skid_vld_q <= 1'b0;
		end else if (push) begin
			skid_vld_q <= 1'b1;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (out_free) begin
			if (skid_vld_q)
				out_q <= skid_q;
			else if (push)
				out_q <= push_beat;
		end else if (push) begin
			skid_q <= push_beat;
		end
	end

	assign full      = skid_vld_q;
	assign out_valid = out_vld_q;
	assign out_beat  = out_q;

endmodule

### verif/chunk_decode_checker.sv
// ----------------------------------------------------------------------------
// chunk_decode_checker: beat predictor and comparator for the chunk decoder
// Follows every accepted input beat with its own copy of the decoder state,
// queues the payload and body end beats it should cause, and compares each
// accepted output beat field by field against the oldest queued one.
// ----------------------------------------------------------------------------
module chunk_decode_checker
	import chd_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic       in_stall,
	input  logic       func,
	input  logic [7:0] byte_in,
	input  logic       out_valid,
	input  logic       out_stall,
	input  logic [7:0] byte_out,
	input  logic       last_of_chunk,
	input  logic       body_end,
	output int         fail_count,
	output int         pending_beats
);

	localparam logic [SIZE_BITS-1:0] SIZE_FULL = '1;

	// shadow decoder state
	phase_t               dec_phase;
	logic [SIZE_BITS-1:0] dec_count;
	int                   dec_line_cnt;
	logic                 dec_prev_cr;
	nstage_t              dec_stage;
	logic                 dec_skip;

	beat_t expected_beats[$];
	beat_t want;
	int    mismatches;
	int    beats_seen;

	// value of a hex digit, -1 for any other character
	function automatic int hex_digit_value(input logic [7:0] c);
		if (c >= CH_ZERO && c <= CH_NINE)
			return int'(c - CH_ZERO);
		if (c >= CH_LA && c <= CH_LF_A)
			return int'(c - CH_LA) + 10;
		if (c >= CH_UA && c <= CH_UF)
			return int'(c - CH_UA) + 10;
		return -1;
	endfunction

	function automatic bit is_blank(input logic [7:0] c);
		case (c)
			CH_SPACE, CH_TAB, CH_LF, CH_VT, CH_FF, CH_CR: return 1'b1;
			default: return 1'b0;
		endcase
	endfunction

	task automatic report_mismatch(input string what, input logic [7:0] got_v,
			input logic [7:0] want_v);
		mismatches++;
		$display("%0t: output beat %0d %s: got %0h, want %0h",
			$time, beats_seen, what, got_v, want_v);
	endtask

	task automatic start_size_line();
		dec_phase    = PH_LINE;
		dec_count    = '0;
		dec_line_cnt = 0;
		dec_prev_cr  = 1'b0;
		dec_stage    = NS_SPACE;
		dec_skip     = 1'b0;
	endtask

	// append one digit, sticking at the counter maximum
	task automatic shift_in_digit(input int d);
		if (dec_count > (SIZE_FULL >> 4))
			dec_count = SIZE_FULL;
		else
			dec_count = {dec_count[SIZE_BITS-5:0], 4'(d)};
	endtask

	// size line number parsing, strtol style
	task automatic parse_size_char(input logic [7:0] c);
		int d;
		d = hex_digit_value(c);
		case (dec_stage)
			NS_SPACE: begin
				if (!is_blank(c)) begin
					if (c == CH_ZERO) begin
						dec_count = '0;
						dec_stage = NS_ZERO;
					end else if (d >= 0) begin
						dec_count = SIZE_BITS'(d);
						dec_stage = NS_DIGITS;
					end else begin
						dec_count = '0;
						dec_stage = NS_DONE;
					end
				end
			end
			NS_ZERO: begin
				if (c == CH_LX || c == CH_UX) begin
					dec_stage = NS_DIGITS;
				end else if (d >= 0) begin
					shift_in_digit(d);
					dec_stage = NS_DIGITS;
				end else begin
					dec_stage = NS_DONE;
				end
			end
			NS_DIGITS: begin
				if (d >= 0)
					shift_in_digit(d);
				else
					dec_stage = NS_DONE;
			end
			default: ;
		endcase
	endtask

	// advance the shadow decoder by one input beat
	task automatic decode_item(input logic f, input logic [7:0] c);
		logic  ended;
		beat_t b;
		b = '0;
		if (f == FUNC_RESTART) begin
			start_size_line();
		end else begin
			case (dec_phase)
				PH_LINE: begin
					if (dec_line_cnt < MAX_LINE - 2)
						parse_size_char(c);
					dec_line_cnt++;
					ended = (dec_prev_cr && c == CH_LF) || dec_line_cnt >= MAX_LINE;
					dec_prev_cr = (c == CH_CR);
					if (ended) begin
						dec_line_cnt = 0;
						dec_prev_cr  = 1'b0;
						dec_stage    = NS_SPACE;
						dec_skip     = 1'b0;
						dec_phase    = (dec_count == '0) ? PH_ENDTRAIL : PH_DATA;
					end
				end
				PH_DATA: begin
					dec_count = dec_count - 1'b1;
					b.byte_out      = c;
					b.last_of_chunk = (dec_count == '0);
					expected_beats.push_back(b);
					if (dec_count == '0) begin
						dec_phase = PH_TRAIL;
						dec_skip  = 1'b0;
					end
				end
				PH_TRAIL: begin
					if (!dec_skip)
						dec_skip = 1'b1;
					else
						start_size_line();
				end
				default: begin
					if (!dec_skip) begin
						dec_skip = 1'b1;
					end else begin
						start_size_line();
						b.body_end = 1'b1;
						expected_beats.push_back(b);
					end
				end
			endcase
		end
	endtask

	// compare output beats first, then predict from the input beat
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_size_line();
			expected_beats.delete();
			mismatches = 0;
			beats_seen = 0;
			fail_count    <= 0;
			pending_beats <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				beats_seen++;
				if (expected_beats.size() == 0) begin
					report_mismatch("arrived with nothing expected", byte_out, 8'h00);
				end else begin
					want = expected_beats.pop_front();
					if (byte_out !== want.byte_out)
						report_mismatch("byte_out", byte_out, want.byte_out);
					if (last_of_chunk !== want.last_of_chunk)
						report_mismatch("last_of_chunk", last_of_chunk, want.last_of_chunk);
					if (body_end !== want.body_end)
						report_mismatch("body_end", body_end, want.body_end);
				end
			end
			if (in_valid && !in_stall)
				decode_item(func, byte_in);
			fail_count    <= mismatches;
			pending_beats <= expected_beats.size();
		end
	end

endmodule

### verif/http_chunked_body_decoder_core_tb.sv
// ----------------------------------------------------------------------------
// http_chunked_body_decoder_core_tb: stimulus and verdict for the decoder
// Streams directed and random chunked bodies (well-formed chunks, end chunks,
// malformed and oversized size lines, noise and restarts) with random idling
// on both sides, and leaves prediction and comparison to the checker.
// ----------------------------------------------------------------------------
module http_chunked_body_decoder_core_tb;
	import chd_pkg::*;

	localparam int ITEM_TARGET    = 1400;
	localparam int HOLD_CYCLES    = 300;
	localparam int WATCHDOG_LIMIT = 3000;
	localparam int DRAIN_CYCLES   = 8;

	logic       clk;
	logic       arst_n;
	logic       in_valid;
	logic       in_stall;
	logic       func;
	logic [7:0] byte_in;
	logic       out_valid;
	logic       out_stall;
	logic [7:0] byte_out;
	logic       last_of_chunk;
	logic       body_end;

	int         fail_count;
	int         pending_beats;
	int         sent;
	int         idle_cycles;
	int         long_lines;
	bit         calm;
	bit         hold_req;
	logic [7:0] line_buf[$];

	http_chunked_body_decoder_core uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.func          (func),
		.byte_in       (byte_in),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.byte_out      (byte_out),
		.last_of_chunk (last_of_chunk),
		.body_end      (body_end)
	);

	chunk_decode_checker checker_i (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.func          (func),
		.byte_in       (byte_in),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.byte_out      (byte_out),
		.last_of_chunk (last_of_chunk),
		.body_end      (body_end),
		.fail_count    (fail_count),
		.pending_beats (pending_beats)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// mostly short pauses, now and then a long one, none while calm
	function automatic int pick_pause();
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 55)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic int chunk_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return $urandom_range(1, 8);
		if (r < 95)
			return $urandom_range(9, 40);
		return $urandom_range(41, 300);
	endfunction

	// receiver: random stall pattern plus a requested long hold-off
	initial begin : receiver
		int run_len;
		int stall_len;
		out_stall = 1'b0;
		@(posedge clk);
		forever begin
			if (hold_req) begin
				hold_req = 1'b0;
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			run_len = $urandom_range(1, 12);
			out_stall <= 1'b0;
			repeat (run_len) @(posedge clk);
			stall_len = pick_pause();
			if (stall_len > 0) begin
				out_stall <= 1'b1;
				repeat (stall_len) @(posedge clk);
			end
		end
	end

	// watchdog on cycles with no beat accepted on either side
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("simulation failed");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// one input beat, then an optional gap
	task automatic send_beat(input logic f, input logic [7:0] c);
		int gap;
		in_valid <= 1'b1;
		func     <= f;
		byte_in  <= c;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		sent++;
		gap = pick_pause();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// input idle until every expected output beat has come out
	task automatic wait_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_beats != 0)
			@(posedge clk);
	endtask

	task automatic send_crlf();
		send_beat(FUNC_BYTE, CH_CR);
		send_beat(FUNC_BYTE, CH_LF);
	endtask

	// line building: never lets CR LF appear before the real line end
	task automatic put_char(input logic [7:0] c);
		if (line_buf.size() > 0 && line_buf[$] == CH_CR && c == CH_LF)
			c = "q";
		line_buf.push_back(c);
	endtask

	task automatic put_text(input string s);
		for (int i = 0; i < s.len(); i++)
			put_char(s[i]);
	endtask

	task automatic put_blanks();
		repeat ($urandom_range(0, 3)) begin
			case ($urandom_range(0, 5))
				0: put_char(CH_SPACE);
				1: put_char(CH_TAB);
				2: put_char(CH_VT);
				3: put_char(CH_FF);
				4: put_char(CH_LF);
				default: put_char(CH_CR);
			endcase
		end
	endtask

	task automatic put_hex(input longint unsigned n);
		logic [7:0] digits[$];
		int         d;
		bit         upper;
		upper = $urandom_range(0, 1);
		do begin
			d = int'(n & 64'hF);
			if (d < 10)
				digits.push_front(CH_ZERO + 8'(d));
			else
				digits.push_front((upper ? CH_UA : CH_LA) + 8'(d - 10));
			n = n >> 4;
		end while (n != 0);
		foreach (digits[i])
			put_char(digits[i]);
	endtask

	task automatic send_buffer();
		foreach (line_buf[i])
			send_beat(FUNC_BYTE, line_buf[i]);
		line_buf.delete();
	endtask

	task automatic send_line();
		send_buffer();
		send_crlf();
	endtask

	// well-formed data chunk with random formatting of its size line
	task automatic send_chunk(input int n);
		put_blanks();
		case ($urandom_range(0, 5))
			0: put_text("0x");
			1: put_text("0X");
			2: put_text("00");
			default: ;
		endcase
		put_hex(longint'(n));
		if ($urandom_range(0, 3) == 0) begin
			put_char(";");
			repeat ($urandom_range(0, 5))
				put_char(8'($urandom_range(0, 255)));
		end
		send_line();
		repeat (n)
			send_beat(FUNC_BYTE, 8'($urandom));
		case ($urandom_range(0, 9))
			0: begin
				send_beat(FUNC_BYTE, 8'($urandom));
				send_beat(FUNC_BYTE, 8'($urandom));
			end
			1: begin
				send_beat(FUNC_BYTE, CH_CR);
				send_beat(FUNC_RESTART, 8'($urandom));
			end
			default: send_crlf();
		endcase
	endtask

	// terminating chunk, including sizes that read as zero
	task automatic send_last();
		put_blanks();
		case ($urandom_range(0, 9))
			0: put_text("0");
			1: put_text("000");
			2: put_text("0x0");
			3: ;
			4: put_text("-5");
			5: put_text("+a");
			6: put_text("zz");
			7: put_text("0x");
			8: put_text("0xg1");
			default: put_text(";name=1");
		endcase
		send_line();
		send_crlf();
	endtask

	// size at or beyond the counter maximum, a few payload beats, then restart
	task automatic send_huge();
		if ($urandom_range(0, 2) == 0)
			put_text("ffffffff");
		else
			put_hex({$urandom, $urandom} | (64'h1 << $urandom_range(32, 63)));
		send_line();
		repeat ($urandom_range(1, 20))
			send_beat(FUNC_BYTE, 8'($urandom));
		send_beat(FUNC_RESTART, 8'($urandom));
	endtask

	// long line that may run into the length limit, digit placed near the parse limit
	task automatic send_long_line();
		int total;
		int pos;
		total = $urandom_range(250, 258);
		pos   = $urandom_range(total - 8, total - 1);
		for (int i = 0; i < total; i++) begin
			if (i < pos)
				put_char($urandom_range(0, 1) ? CH_SPACE : CH_TAB);
			else if (i == pos)
				put_char(CH_ZERO + 8'($urandom_range(1, 9)));
			else
				put_char("g");
		end
		send_buffer();
		repeat ($urandom_range(0, 4))
			send_beat(FUNC_BYTE, 8'($urandom));
		send_beat(FUNC_RESTART, 8'($urandom));
	endtask

	// random beats and commands, then resync
	task automatic send_noise();
		repeat ($urandom_range(1, 8))
			send_beat(($urandom_range(0, 9) == 0) ? FUNC_RESTART : FUNC_BYTE,
				8'($urandom));
		send_beat(FUNC_RESTART, 8'($urandom));
	endtask

	initial begin : stimulus
		int pick;
		bit held;
		bit paused;
		in_valid = 1'b0;
		func     = FUNC_BYTE;
		byte_in  = 8'h00;
		arst_n   = 1'b0;
		sent       = 0;
		long_lines = 0;
		calm       = 1'b0;
		hold_req   = 1'b0;
		held       = 1'b0;
		paused     = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: byte extremes, sign, bare prefix, restart inside payload
		put_text("0x3");
		send_line();
		send_beat(FUNC_BYTE, 8'h00);
		send_beat(FUNC_BYTE, 8'hFF);
		send_beat(FUNC_BYTE, 8'h5A);
		send_crlf();
		put_text("-1");
		send_line();
		send_crlf();
		put_text("0x");
		send_line();
		send_crlf();
		put_text("2");
		send_line();
		send_beat(FUNC_BYTE, 8'hA5);
		send_beat(FUNC_RESTART, 8'hFF);

		// random bodies
		while (sent < ITEM_TARGET) begin
			if ($urandom_range(0, 39) == 0)
				calm = !calm;
			if (!held && sent > 450) begin
				// receiver holds off while a long chunk is pushed in
				held     = 1'b1;
				hold_req = 1'b1;
				send_chunk(128);
			end else if (!paused && sent > 900) begin
				paused = 1'b1;
				wait_drained();
			end else begin
				pick = $urandom_range(0, 99);
				if (pick < 60)
					send_chunk(chunk_len());
				else if (pick < 75)
					send_last();
				else if (pick < 79)
					send_huge();
				else if (pick < 81 && long_lines < 2) begin
					long_lines++;
					send_long_line();
				end else if (pick < 94)
					send_noise();
				else if (pick < 99)
					send_beat(FUNC_RESTART, 8'($urandom));
				else
					wait_drained();
			end
		end

		// drain and verdict
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_beats != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0 && pending_beats == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

### filelist.f
hdl/chd_pkg.sv
hdl/chd_step.sv
hdl/chd_out_skid.sv
hdl/http_chunked_body_decoder_core.sv
verif/chunk_decode_checker.sv
verif/http_chunked_body_decoder_core_tb.sv
